[design/mtsfm_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the mono to stereo fir mixer
// no dependencies; used by every module of the block

package mtsfm_pkg;

	localparam int MAX_TAPS   = 256;
	localparam int ADDR_W     = $clog2(MAX_TAPS);
	localparam int TAP_CNT_W  = $clog2(MAX_TAPS + 1);
	localparam int IDX_W      = 8;
	localparam int SMP_W      = 16;
	localparam int ACC_W      = 40;
	localparam int GAIN_W     = 7;
	localparam int GAIN_FULL  = 127;

	localparam logic signed [ACC_W-1:0] ACC_ROUND  = ACC_W'(1 << 14);
	localparam logic signed [ACC_W-1:0] ACC_SAT_HI = 40'sh00_3FFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_SAT_LO = 40'shFF_C000_0000;

	// register indexes of the configuration port
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_MIX_GAIN  = 1'b1;
	localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = TAP_CNT_W'(1);
	localparam logic [GAIN_W-1:0]    MIX_GAIN_RST  = GAIN_W'(GAIN_FULL);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PUSH = 1'b1
	} op_t;

	// one classified request between front and back
	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        idx;
		logic signed [SMP_W-1:0] d0;   // tap_left or sample
		logic signed [SMP_W-1:0] d1;   // tap_right or mix_left
		logic signed [SMP_W-1:0] d2;   // mix_right
	} entry_t;

	// filter sums and mix values handed from the mac to the output stage
	typedef struct packed {
		logic signed [ACC_W-1:0] acc_l;
		logic signed [ACC_W-1:0] acc_r;
		logic signed [SMP_W-1:0] mix_l;
		logic signed [SMP_W-1:0] mix_r;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} mac_state_t;

endpackage

[design/mtsfm_front.sv]
`timescale 1ns / 1ps
// front end: accepts requests, classifies them and holds them in a two-entry queue
// depends on mtsfm_pkg

module mtsfm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [7:0]          tap_index,
	input  logic signed [15:0]  tap_left,
	input  logic signed [15:0]  tap_right,
	input  logic signed [15:0]  sample,
	input  logic signed [15:0]  mix_left,
	input  logic signed [15:0]  mix_right,
	output mtsfm_pkg::entry_t   head,
	output logic                head_valid,
	input  logic                pop
);

	mtsfm_pkg::entry_t buf_q [2];
	mtsfm_pkg::entry_t entry;
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;
	logic              push_in;
	logic              pop_ok;

	always_comb begin
		entry.op  = mtsfm_pkg::op_t'(cmd);
		entry.idx = tap_index;
		if (entry.op == mtsfm_pkg::OP_PUSH) begin
			entry.d0 = sample;
			entry.d1 = mix_left;
			entry.d2 = mix_right;
		end else begin
			entry.d0 = tap_left;
			entry.d1 = tap_right;
			entry.d2 = '0;
		end
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push_in    = in_valid && in_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign pop_ok     = pop && head_valid;
	assign head       = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_in) begin
			buf_q[wr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_in) begin
				wr_q <= ~wr_q;
			end
			if (pop_ok) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push_in) - 2'(pop_ok);
		end
	end

endmodule

[design/mtsfm_mac.sv]
`timescale 1ns / 1ps
// back end: coefficient and delay line memories, tap sequencer and shared stereo mac
// depends on mtsfm_pkg

module mtsfm_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [mtsfm_pkg::TAP_CNT_W-1:0]      tap_count,
	input  mtsfm_pkg::entry_t                    head,
	input  logic                                 head_valid,
	output logic                                 pop,
	output mtsfm_pkg::res_t                      res,
	output logic                                 res_valid,
	input  logic                                 res_ready
);

	localparam int AW = mtsfm_pkg::ADDR_W;
	localparam int CW = mtsfm_pkg::TAP_CNT_W;
	localparam int SW = mtsfm_pkg::SMP_W;
	localparam int PW = 2 * mtsfm_pkg::SMP_W;

	logic [PW-1:0] coef_mem [mtsfm_pkg::MAX_TAPS];
	logic [SW-1:0] dly_mem  [mtsfm_pkg::MAX_TAPS];

	mtsfm_pkg::mac_state_t state_q, state_nxt;

	logic [AW-1:0] slot_q;
	logic [AW-1:0] slot_nxt;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] taps_q;
	logic [CW-1:0] taps_lim;
	logic signed [SW-1:0] mix_l_q, mix_r_q;
	logic signed [mtsfm_pkg::ACC_W-1:0] acc_l_q, acc_r_q;

	logic          v_s1, ok_s1;
	logic [PW-1:0] coef_s1;
	logic [SW-1:0] smp_s1;
	logic          v_s2;
	logic signed [PW-1:0] prod_l_s2, prod_r_s2;
	logic signed [SW-1:0] smp_eff;

	logic load_we, push_go, issue;

	assign slot_nxt = slot_q + AW'(1);
	assign taps_lim = (tap_count > CW'(mtsfm_pkg::MAX_TAPS)) ?
		CW'(mtsfm_pkg::MAX_TAPS) : tap_count;
	assign issue    = (state_q == mtsfm_pkg::ST_RUN) && (j_q < taps_q);
	assign smp_eff  = ok_s1 ? $signed(smp_s1) : '0;

	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			mtsfm_pkg::ST_IDLE: begin
				pop = head_valid;
				if (head_valid && head.op == mtsfm_pkg::OP_PUSH) begin
					state_nxt = mtsfm_pkg::ST_RUN;
				end
			end
			mtsfm_pkg::ST_RUN: begin
				if (!issue) begin
					state_nxt = mtsfm_pkg::ST_DRAIN;
				end
			end
			mtsfm_pkg::ST_DRAIN: begin
				// sums are complete once both mac stages are empty
				if (!v_s1 && !v_s2) begin
					state_nxt = mtsfm_pkg::ST_DONE;
				end
			end
			mtsfm_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_nxt = mtsfm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = mtsfm_pkg::ST_IDLE;
			end
		endcase
	end

	assign load_we = pop && (head.op == mtsfm_pkg::OP_LOAD);
	assign push_go = pop && (head.op == mtsfm_pkg::OP_PUSH);

	assign res.acc_l = acc_l_q;
	assign res.acc_r = acc_r_q;
	assign res.mix_l = mix_l_q;
	assign res.mix_r = mix_r_q;

	// memories, read data registered
	always_ff @(posedge clk) begin
		if (load_we) begin
			coef_mem[head.idx[AW-1:0]] <= {head.d0, head.d1};
		end
		if (push_go) begin
			dly_mem[slot_nxt] <= head.d0;
		end
		coef_s1 <= coef_mem[j_q[AW-1:0]];
		smp_s1  <= dly_mem[slot_q - j_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		prod_l_s2 <= $signed(coef_s1[PW-1:SW]) * smp_eff;
		prod_r_s2 <= $signed(coef_s1[SW-1:0]) * smp_eff;
		if (push_go) begin
			mix_l_q <= head.d1;
			mix_r_q <= head.d2;
			acc_l_q <= mtsfm_pkg::ACC_ROUND;
			acc_r_q <= mtsfm_pkg::ACC_ROUND;
		end else if (v_s2) begin
			acc_l_q <= acc_l_q + mtsfm_pkg::ACC_W'(prod_l_s2);
			acc_r_q <= acc_r_q + mtsfm_pkg::ACC_W'(prod_r_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtsfm_pkg::ST_IDLE;
			slot_q  <= '0;
			fill_q  <= '0;
			j_q     <= '0;
			taps_q  <= '0;
			v_s1    <= 1'b0;
			ok_s1   <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			v_s1    <= issue;
			// taps older than the number of samples seen read as zero
			ok_s1   <= (j_q < fill_q);
			v_s2    <= v_s1;
			if (push_go) begin
				slot_q <= slot_nxt;
				if (fill_q != CW'(mtsfm_pkg::MAX_TAPS)) begin
					fill_q <= fill_q + CW'(1);
				end
				j_q    <= '0;
				taps_q <= taps_lim;
			end else if (issue) begin
				j_q <= j_q + CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(mtsfm_pkg::MAX_TAPS))
		else $error("fill count beyond delay line depth");

	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mtsfm_pkg::ST_DONE |-> !v_s1 && !v_s2)
		else $error("result offered with products still in flight");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mtsfm_pkg::ST_RUN |-> j_q <= taps_q)
		else $error("tap counter ran past tap count");

	a_issue_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		push_go |=> state_q == mtsfm_pkg::ST_RUN && j_q == '0)
		else $error("push did not start a tap sweep");
`endif

endmodule

[design/mtsfm_post.sv]
`timescale 1ns / 1ps
// output stage: saturate and scale the sums, apply gain/127, add mix, hold the result
// depends on mtsfm_pkg

module mtsfm_post (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mtsfm_pkg::GAIN_W-1:0]       mix_gain,
	input  mtsfm_pkg::res_t                    res,
	input  logic                               res_valid,
	output logic                               res_ready,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [15:0]                 mixed_left,
	output logic signed [15:0]                 mixed_right
);

	localparam int SW = mtsfm_pkg::SMP_W;
	localparam int MW = SW + mtsfm_pkg::GAIN_W + 1;

	// clamp to [-2^30, 2^30-1] then arithmetic shift by 15
	function automatic logic signed [SW-1:0] sat_shift(logic signed [mtsfm_pkg::ACC_W-1:0] a);
		logic signed [mtsfm_pkg::ACC_W-1:0] c;
		c = a;
		if (a > mtsfm_pkg::ACC_SAT_HI) begin
			c = mtsfm_pkg::ACC_SAT_HI;
		end else if (a < mtsfm_pkg::ACC_SAT_LO) begin
			c = mtsfm_pkg::ACC_SAT_LO;
		end
		return c[30:15];
	endfunction

	// quotient estimate by 1/127 = sum of 128^-k, exact within three counts
	function automatic logic [SW-1:0] quot_est(logic [MW-1:0] a);
		return SW'(a >> 7) + SW'(a >> 14) + SW'(a >> 21);
	endfunction

	function automatic logic [9:0] rem_est(logic [MW-1:0] a, logic [SW-1:0] q0);
		logic [MW-1:0] m;
		m = (MW'(q0) << 7) - MW'(q0);
		return 10'(a - m);
	endfunction

	function automatic logic [SW-1:0] quot_fix(logic [SW-1:0] q0, logic [9:0] r);
		logic [SW-1:0] q;
		logic [9:0]    rr;
		q  = q0;
		rr = r;
		for (int i = 0; i < 4; i++) begin
			if (rr >= 10'(mtsfm_pkg::GAIN_FULL)) begin
				rr = rr - 10'(mtsfm_pkg::GAIN_FULL);
				q  = q + SW'(1);
			end
		end
		return q;
	endfunction

	function automatic logic signed [SW-1:0] mix_sat(logic neg, logic [SW-1:0] q,
		logic signed [SW-1:0] mix);
		logic signed [SW:0]   sq;
		logic signed [SW+1:0] sum;
		sq  = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		sum = (SW+2)'(sq) + (SW+2)'(mix);
		if (sum > (SW+2)'(32767)) begin
			return 16'sh7FFF;
		end else if (sum < -(SW+2)'(32768)) begin
			return 16'sh8000;
		end
		return sum[SW-1:0];
	endfunction

	logic              v_s1, v_s2;
	logic signed [MW-1:0] p_l_s1, p_r_s1;
	logic signed [SW-1:0] mix_l_s1, mix_r_s1, mix_l_s2, mix_r_s2;
	logic              neg_l_s2, neg_r_s2;
	logic [SW-1:0]     q0_l_s2, q0_r_s2;
	logic [9:0]        r_l_s2, r_r_s2;
	logic              out_v_q;
	logic signed [SW-1:0] mixed_left_q, mixed_right_q;
	logic [MW-1:0]     a_l, a_r;
	logic              adv_out, adv_s2, s2_free;

	assign adv_out   = v_s2 && (!out_v_q || out_ready);
	assign s2_free   = !v_s2 || adv_out;
	assign adv_s2    = v_s1 && s2_free;
	assign res_ready = !v_s1 || adv_s2;

	assign a_l = p_l_s1[MW-1] ? MW'(-p_l_s1) : MW'(p_l_s1);
	assign a_r = p_r_s1[MW-1] ? MW'(-p_r_s1) : MW'(p_r_s1);

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			p_l_s1   <= sat_shift(res.acc_l) * $signed({1'b0, mix_gain});
			p_r_s1   <= sat_shift(res.acc_r) * $signed({1'b0, mix_gain});
			mix_l_s1 <= res.mix_l;
			mix_r_s1 <= res.mix_r;
		end
		if (adv_s2) begin
			neg_l_s2 <= p_l_s1[MW-1];
			neg_r_s2 <= p_r_s1[MW-1];
			q0_l_s2  <= quot_est(a_l);
			q0_r_s2  <= quot_est(a_r);
			r_l_s2   <= rem_est(a_l, quot_est(a_l));
			r_r_s2   <= rem_est(a_r, quot_est(a_r));
			mix_l_s2 <= mix_l_s1;
			mix_r_s2 <= mix_r_s1;
		end
		if (adv_out) begin
			mixed_left_q  <= mix_sat(neg_l_s2, quot_fix(q0_l_s2, r_l_s2), mix_l_s2);
			mixed_right_q <= mix_sat(neg_r_s2, quot_fix(q0_r_s2, r_r_s2), mix_r_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (res_ready) begin
				v_s1 <= res_valid;
			end
			if (s2_free) begin
				v_s2 <= adv_s2;
			end
			if (adv_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign mixed_left  = mixed_left_q;
	assign mixed_right = mixed_right_q;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mixed_left) && $stable(mixed_right))
		else $error("held result overwritten");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_out |=> v_s2 && $stable(q0_l_s2) && $stable(r_l_s2))
		else $error("stalled quotient stage lost its value");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> r_l_s2 < 10'd508 && r_r_s2 < 10'd508)
		else $error("quotient estimate off by more than three");
`endif

endmodule

[design/mono_to_stereo_fir_mixer.sv]
`timescale 1ns / 1ps
// a push is queued, swept over the taps by the mac, then scaled and mixed in the output stage
// the next push starts once the last sums go to the output stage; taps above 256 count as 256
// one shared stereo mac walks the taps one per cycle; loads retire one per cycle when it idles
// reset: registers return to tap_count 1, mix_gain 127; the delay line reads as zero through
// a fill count, so no clearing pass; coefficients are undefined until loaded
// depends on mtsfm_pkg, mtsfm_front, mtsfm_mac, mtsfm_post

module mono_to_stereo_fir_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [7:0]          tap_index,
	input  logic signed [15:0]  tap_left,
	input  logic signed [15:0]  tap_right,
	input  logic signed [15:0]  sample,
	input  logic signed [15:0]  mix_left,
	input  logic signed [15:0]  mix_right,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  mixed_left,
	output logic signed [15:0]  mixed_right
);

	logic [mtsfm_pkg::TAP_CNT_W-1:0] tap_count_q;
	logic [mtsfm_pkg::GAIN_W-1:0]    mix_gain_q;
	logic [mtsfm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                            wr_en;

	mtsfm_pkg::entry_t head;
	logic              head_valid;
	logic              pop;
	mtsfm_pkg::res_t   res;
	logic              res_valid;
	logic              res_ready;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= mtsfm_pkg::TAP_COUNT_RST;
			mix_gain_q  <= mtsfm_pkg::MIX_GAIN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mtsfm_pkg::REG_TAP_COUNT: tap_count_q <= pwdata[mtsfm_pkg::TAP_CNT_W-1:0];
				mtsfm_pkg::REG_MIX_GAIN:  mix_gain_q  <= pwdata[mtsfm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mtsfm_pkg::REG_TAP_COUNT: prdata = 32'(tap_count_q);
			mtsfm_pkg::REG_MIX_GAIN:  prdata = 32'(mix_gain_q);
			default:                  prdata = '0;
		endcase
	end

	mtsfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.tap_index  (tap_index),
		.tap_left   (tap_left),
		.tap_right  (tap_right),
		.sample     (sample),
		.mix_left   (mix_left),
		.mix_right  (mix_right),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	mtsfm_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.tap_count  (tap_count_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res        (res),
		.res_valid  (res_valid),
		.res_ready  (res_ready)
	);

	mtsfm_post u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.mix_gain    (mix_gain_q),
		.res         (res),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mixed_left  (mixed_left),
		.mixed_right (mixed_right)
	);

endmodule
